>>> rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_t;

  typedef struct packed {
    logic       w_load;
    logic       v_load;
    logic       round;
    logic       v_shift;
    logic [5:0] k_idx;
  } core_ctrl_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

>>> rtl/sha256_if.sv
// ----------------------------------------------------------------------------
// sha256 channel interfaces
// Valid/ready channels for message requests and digest words.
// ----------------------------------------------------------------------------
interface sha256_msg_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface sha256_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

>>> rtl/sha256_core.sv
// ----------------------------------------------------------------------------
// sha256_core
// Message schedule shift line and working variables a..h; one round a cycle.
// ----------------------------------------------------------------------------
module sha256_core
  import sha256_pkg::*;
(
  input  logic        clk,
  input  core_ctrl_t  ctrl,
  input  logic [31:0] buf_word,
  input  logic [31:0] hash_word,
  output logic [31:0] a_word
);

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  assign w_new = small_sig1(w[14]) + w[9] + small_sig0(w[1]) + w[0];
  assign t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + ROUND_K[ctrl.k_idx] + w[0];
  assign t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign a_word = v[0];

  always_ff @(posedge clk) begin
    if (ctrl.w_load || ctrl.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= ctrl.round ? w_new : buf_word;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.round) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
    end else if (ctrl.v_load || ctrl.v_shift) begin
      for (int i = 0; i < 7; i++) v[i] <= v[i+1];
      v[7] <= ctrl.v_load ? hash_word : v[0];
    end
  end

endmodule

>>> rtl/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// Byte-serial SHA-256: block buffer and chaining state in memories with one write and one read port.
// ----------------------------------------------------------------------------
// Append: a byte is taken while idle; the 64th byte of a block starts a compression
//   (load, 64 rounds, hash write-back), and no byte is taken until it ends.
// Finish: padding writes, one or two compressions, then 8 digest words one at a time,
//   each held until the sink is ready; once done, a finish resends the words.
// Reset: synchronous; chaining entries read as H0..H7 until first written,
//   through per-entry valid bits, so no clearing pass is needed.
module sha256_stream_hasher_top
  import sha256_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  sha256_msg_if.sink             msg,
  sha256_digest_if.source        digest
);

  state_t state;
  state_t state_next;

  logic [5:0]  cnt;
  logic [54:0] blocks;
  logic        done;
  logic        two;
  logic        fin;
  logic [3:0]  wp;
  logic [4:0]  lc;
  logic [5:0]  rnd;
  logic [3:0]  uc;
  logic [2:0]  idx;
  logic [7:0]  hv;
  logic        out_valid;
  logic [31:0] acc;
  logic [31:0] out_word;
  logic [2:0]  out_idx;

  logic        accept;
  logic [3:0]  wi;
  logic [63:0] len;

  logic [31:0] buf_mem [16];
  logic        buf_we;
  logic [3:0]  buf_waddr;
  logic [31:0] buf_wdata;
  logic [31:0] buf_rd;

  logic [31:0] hash_mem [8];
  logic [2:0]  hash_raddr;
  logic        hash_we;
  logic [2:0]  hash_waddr;
  logic [31:0] hash_rd;
  logic [2:0]  hash_rd_addr;
  logic        hash_rd_valid;
  logic [31:0] hash_q;

  core_ctrl_t  ctrl;
  logic [31:0] a_word;

  assign accept = msg.valid && msg.ready;
  assign wi     = cnt[5:2];
  assign len    = {blocks, cnt, 3'b000};
  assign hash_q = hash_rd_valid ? hash_rd : INIT_H[hash_rd_addr];

  assign digest.valid       = out_valid;
  assign digest.digest_word = out_word;
  assign digest.word_index  = out_idx;
  assign digest.last_word   = (out_idx == 3'd7);

  function automatic logic [31:0] pad_word(input logic [31:0] a, input logic [1:0] p);
    logic [31:0] r;
    r = '0;
    unique case (p)
      2'd0: r = {PAD_BYTE, 24'h0};
      2'd1: r = {a[31:24], PAD_BYTE, 16'h0};
      2'd2: r = {a[31:16], PAD_BYTE, 8'h0};
      2'd3: r = {a[31:8], PAD_BYTE};
    endcase
    return r;
  endfunction

  // memories
  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_waddr] <= buf_wdata;
    buf_rd <= buf_mem[lc[3:0]];
  end

  always_ff @(posedge clk) begin
    if (hash_we) hash_mem[hash_waddr] <= hash_q + a_word;
    hash_rd      <= hash_mem[hash_raddr];
    hash_rd_addr <= hash_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hv            <= '0;
      hash_rd_valid <= 1'b0;
    end else begin
      hash_rd_valid <= hv[hash_raddr] && !(hash_we && hash_waddr == hash_raddr);
      if (hash_we) hv[hash_waddr] <= 1'b1;
    end
  end

  sha256_core u_core (
    .clk       (clk),
    .ctrl      (ctrl),
    .buf_word  (buf_rd),
    .hash_word (hash_q),
    .a_word    (a_word)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (msg.kind == KIND_FINISH) begin
            if (done)          state_next = ST_EMIT_RD;
            else if (wi == 4'd15) state_next = ST_LOAD;
            else               state_next = ST_FILL;
          end else if (!done && cnt == 6'd63) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_FILL:      if (wp == 4'd15) state_next = ST_LOAD;
      ST_LOAD:      if (lc == 5'd16) state_next = ST_ROUND;
      ST_ROUND:     if (rnd == 6'd63) state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (uc == 4'd8) begin
          priority if (two) state_next = ST_FILL;
          else if (fin)     state_next = ST_EMIT_RD;
          else              state_next = ST_IDLE;
        end
      end
      ST_EMIT_RD:   state_next = ST_EMIT_LD;
      ST_EMIT_LD:   state_next = ST_EMIT_HOLD;
      ST_EMIT_HOLD: begin
        if (digest.ready) state_next = (idx == 3'd7) ? ST_IDLE : ST_EMIT_RD;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    msg.ready   = 1'b0;
    buf_we      = 1'b0;
    buf_waddr   = wp;
    buf_wdata   = '0;
    hash_raddr  = idx;
    hash_we     = 1'b0;
    hash_waddr  = uc[2:0] - 3'd1;
    ctrl        = '0;
    ctrl.k_idx  = rnd;
    unique case (state)
      ST_IDLE: begin
        msg.ready = 1'b1;
        buf_waddr = wi;
        if (accept && !done) begin
          if (msg.kind == KIND_FINISH) begin
            buf_we    = 1'b1;
            buf_wdata = pad_word(acc, cnt[1:0]);
          end else if (cnt[1:0] == 2'd3) begin
            buf_we    = 1'b1;
            buf_wdata = {acc[31:8], msg.data_byte};
          end
        end
      end
      ST_FILL: begin
        buf_we = 1'b1;
        if (!two && wp == 4'd14)      buf_wdata = len[63:32];
        else if (!two && wp == 4'd15) buf_wdata = len[31:0];
        else                          buf_wdata = '0;
      end
      ST_LOAD: begin
        hash_raddr   = lc[2:0];
        ctrl.w_load  = (lc != 5'd0);
        ctrl.v_load  = (lc != 5'd0) && (lc <= 5'd8);
      end
      ST_ROUND:  ctrl.round = 1'b1;
      ST_UPDATE: begin
        hash_raddr   = uc[2:0];
        hash_we      = (uc != 4'd0);
        ctrl.v_shift = (uc != 4'd0);
      end
      ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_HOLD: hash_raddr = idx;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      blocks    <= '0;
      done      <= 1'b0;
      two       <= 1'b0;
      fin       <= 1'b0;
      wp        <= '0;
      lc        <= '0;
      rnd       <= '0;
      uc        <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      lc    <= (state == ST_LOAD) ? lc + 5'd1 : '0;
      rnd   <= (state == ST_ROUND) ? rnd + 6'd1 : '0;
      uc    <= (state == ST_UPDATE) ? uc + 4'd1 : '0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (msg.kind == KIND_FINISH) begin
              idx <= '0;
              if (!done) begin
                fin <= 1'b1;
                two <= (cnt[5:3] == 3'b111);
                wp  <= wi + 4'd1;
              end
            end else if (!done) begin
              cnt <= cnt + 6'd1;
              if (cnt == 6'd63) blocks <= blocks + 55'd1;
            end
          end
        end
        ST_FILL: wp <= wp + 4'd1;
        ST_UPDATE: begin
          if (uc == 4'd8) begin
            if (two) begin
              two <= 1'b0;
              wp  <= '0;
            end else if (fin) begin
              done <= 1'b1;
              idx  <= '0;
            end
          end
        end
        ST_EMIT_LD: out_valid <= 1'b1;
        ST_EMIT_HOLD: begin
          if (digest.ready) begin
            out_valid <= 1'b0;
            idx       <= idx + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && msg.kind == KIND_APPEND && !done) begin
      unique case (cnt[1:0])
        2'd0: acc[31:24] <= msg.data_byte;
        2'd1: acc[23:16] <= msg.data_byte;
        2'd2: acc[15:8]  <= msg.data_byte;
        2'd3: acc[7:0]   <= msg.data_byte;
      endcase
    end
    if (state == ST_EMIT_LD) begin
      out_word <= hash_q;
      out_idx  <= idx;
    end
  end

endmodule
